@@ sv/wahd_pkg.sv @@
// Shared types and constants for the window alarm with hysteresis and delay.
package wahd_pkg;

   // Field widths fixed by the register map and the result word
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int LIMIT_BITS      = 16;
   localparam int HYST_BITS       = 15;
   localparam int DELAY_BITS      = 16;
   localparam int ZONE_BITS       = 2;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 16;
   localparam int RSP_DATA_BITS   = 8;

   // Item kind carried in req_tuser
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // Register indexes
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_HIGH_LIMIT  = 3'd0,
      CSR_LOW_LIMIT   = 3'd1,
      CSR_HYSTERESIS  = 3'd2,
      CSR_LOW_DELAY   = 3'd3,
      CSR_HIGH_DELAY  = 3'd4
   } csr_index_type;

   // Alarm zone codes
   typedef enum logic [ZONE_BITS-1:0] {
      ZONE_NORMAL = 2'd0,
      ZONE_HIGH   = 2'd1,
      ZONE_LOW    = 2'd2
   } zone_type;

   // Configuration handed to the alarm core
   typedef struct packed {
      logic signed [LIMIT_BITS-1:0] high_limit;
      logic signed [LIMIT_BITS-1:0] low_limit;
      logic [HYST_BITS-1:0]         hysteresis;
      logic [DELAY_BITS-1:0]        low_delay;
      logic [DELAY_BITS-1:0]        high_delay;
   } cfg_type;

   // Visible alarm status after the last processed word
   typedef struct packed {
      zone_type zone;
      logic     alarm_low;
      logic     alarm_high;
   } status_type;

endpackage

@@ sv/wahd_core.sv @@
// Zone tracking, delay counters and confirmed alarm flags.
module wahd_core #(
   parameter int SAMPLE_BITS = wahd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          kind,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  wahd_pkg::cfg_type             cfg,
   output wahd_pkg::status_type          status
);
   import wahd_pkg::*;

   // Compare width: holds any sample and any limit plus or minus the band
   localparam int CW = ((SAMPLE_BITS > LIMIT_BITS + 1) ? SAMPLE_BITS : LIMIT_BITS + 1) + 1;

   zone_type              zone_ff, zone_in;
   logic                  alarm_low_ff, alarm_low_in;
   logic                  alarm_high_ff, alarm_high_in;
   logic [DELAY_BITS-1:0] low_count_ff, low_count_in;
   logic [DELAY_BITS-1:0] high_count_ff, high_count_in;
   logic                  low_run_ff, low_run_in;
   logic                  high_run_ff, high_run_in;

   logic signed [CW-1:0] s_ext;
   logic signed [CW-1:0] hyst_ext;
   logic signed [CW-1:0] hi_up;
   logic signed [CW-1:0] hi_dn;
   logic signed [CW-1:0] lo_up;
   logic signed [CW-1:0] lo_dn;
   logic                 above_hi_up;
   logic                 below_hi_dn;
   logic                 above_lo_up;
   logic                 below_lo_dn;

   // Form the widened and narrowed thresholds at full precision
   assign s_ext    = CW'(sample);
   assign hyst_ext = CW'({1'b0, cfg.hysteresis});
   assign hi_up    = CW'(cfg.high_limit) + hyst_ext;
   assign hi_dn    = CW'(cfg.high_limit) - hyst_ext;
   assign lo_up    = CW'(cfg.low_limit) + hyst_ext;
   assign lo_dn    = CW'(cfg.low_limit) - hyst_ext;

   assign above_hi_up = s_ext > hi_up;
   assign below_hi_dn = s_ext < hi_dn;
   assign above_lo_up = s_ext > lo_up;
   assign below_lo_dn = s_ext < lo_dn;

   // Next state for one sample or one tick
   always_comb begin
      zone_in       = zone_ff;
      alarm_low_in  = alarm_low_ff;
      alarm_high_in = alarm_high_ff;
      low_count_in  = low_count_ff;
      high_count_in = high_count_ff;
      low_run_in    = low_run_ff;
      high_run_in   = high_run_ff;

      if (kind == KIND_TICK) begin
         // Count down running delays; confirm only if still in that zone
         if (low_run_ff) begin
            if (low_count_ff <= DELAY_BITS'(1)) begin
               low_count_in = '0;
               low_run_in   = 1'b0;
               if (zone_ff == ZONE_LOW) begin
                  alarm_low_in = 1'b1;
               end
            end else begin
               low_count_in = low_count_ff - DELAY_BITS'(1);
            end
         end
         if (high_run_ff) begin
            if (high_count_ff <= DELAY_BITS'(1)) begin
               high_count_in = '0;
               high_run_in   = 1'b0;
               if (zone_ff == ZONE_HIGH) begin
                  alarm_high_in = 1'b1;
               end
            end else begin
               high_count_in = high_count_ff - DELAY_BITS'(1);
            end
         end
      end else begin
         // Move the zone; entering a fault zone reloads its delay
         case (zone_ff)
            ZONE_HIGH: begin
               if (below_lo_dn) begin
                  zone_in       = ZONE_LOW;
                  alarm_high_in = 1'b0;
                  low_count_in  = cfg.low_delay;
                  low_run_in    = 1'b1;
               end else if (below_hi_dn) begin
                  zone_in       = ZONE_NORMAL;
                  alarm_high_in = 1'b0;
               end
            end
            ZONE_LOW: begin
               if (above_hi_up) begin
                  zone_in       = ZONE_HIGH;
                  alarm_low_in  = 1'b0;
                  high_count_in = cfg.high_delay;
                  high_run_in   = 1'b1;
               end else if (above_lo_up) begin
                  zone_in      = ZONE_NORMAL;
                  alarm_low_in = 1'b0;
               end
            end
            default: begin
               zone_in = ZONE_NORMAL;
               if (above_hi_up) begin
                  zone_in       = ZONE_HIGH;
                  alarm_low_in  = 1'b0;
                  high_count_in = cfg.high_delay;
                  high_run_in   = 1'b1;
               end else if (below_lo_dn) begin
                  zone_in       = ZONE_LOW;
                  alarm_high_in = 1'b0;
                  low_count_in  = cfg.low_delay;
                  low_run_in    = 1'b1;
               end
            end
         endcase
      end
   end

   // Advance state once per processed word
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff       <= ZONE_NORMAL;
         alarm_low_ff  <= 1'b0;
         alarm_high_ff <= 1'b0;
         low_count_ff  <= '0;
         high_count_ff <= '0;
         low_run_ff    <= 1'b0;
         high_run_ff   <= 1'b0;
      end else if (step) begin
         zone_ff       <= zone_in;
         alarm_low_ff  <= alarm_low_in;
         alarm_high_ff <= alarm_high_in;
         low_count_ff  <= low_count_in;
         high_count_ff <= high_count_in;
         low_run_ff    <= low_run_in;
         high_run_ff   <= high_run_in;
      end
   end

   assign status.zone       = zone_ff;
   assign status.alarm_low  = alarm_low_ff;
   assign status.alarm_high = alarm_high_ff;

endmodule

@@ sv/window_alarm_with_hysteresis_delay.sv @@
// Top level: stream ports, register file, input stage and result handshake.
// A word waits in the input stage until processed into the state registers.
// Throughput: one word per cycle; the state registers hold the result word,
// so a word is processed whenever the result slot is empty or being taken.
// Reset (synchronous, active high): zone normal, alarms and counters cleared,
// limits and band zero, both delays one.
module window_alarm_with_hysteresis_delay #(
   parameter int SAMPLE_BITS = wahd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // req_tdata: sample [SAMPLE_BITS-1:0], zero padded to whole bytes
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]     req_tdata,
   // req_tuser: kind [0]
   input  logic                                         req_tuser,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // rsp_tdata: zone [1:0], alarm_low [2], alarm_high [3], zero padded
   output logic [wahd_pkg::RSP_DATA_BITS-1:0]           rsp_tdata,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   input  logic                                         csr_we,
   input  logic [wahd_pkg::CSR_ADDR_BITS-1:0]           csr_addr,
   input  logic [wahd_pkg::CSR_DATA_BITS-1:0]           csr_wdata
);
   import wahd_pkg::*;

   cfg_type cfg_ff;

   logic                          in_valid_ff, in_valid_in;
   logic                          in_kind_ff;
   logic signed [SAMPLE_BITS-1:0] in_sample_ff;
   logic                          out_valid_ff, out_valid_in;
   logic                          advance;
   status_type                    status;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_limit <= '0;
         cfg_ff.low_limit  <= '0;
         cfg_ff.hysteresis <= '0;
         cfg_ff.low_delay  <= DELAY_BITS'(1);
         cfg_ff.high_delay <= DELAY_BITS'(1);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_HIGH_LIMIT: cfg_ff.high_limit <= csr_wdata[LIMIT_BITS-1:0];
            CSR_LOW_LIMIT:  cfg_ff.low_limit  <= csr_wdata[LIMIT_BITS-1:0];
            CSR_HYSTERESIS: cfg_ff.hysteresis <= csr_wdata[HYST_BITS-1:0];
            CSR_LOW_DELAY:  cfg_ff.low_delay  <= csr_wdata[DELAY_BITS-1:0];
            CSR_HIGH_DELAY: cfg_ff.high_delay <= csr_wdata[DELAY_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Process the held word when the result slot is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Hold control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the input word
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff   <= req_tuser;
         in_sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
   end

   wahd_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .kind   (in_kind_ff),
      .sample (in_sample_ff),
      .cfg    (cfg_ff),
      .status (status)
   );

   // Drive the result word from the state registers
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - ZONE_BITS - 2){1'b0}},
                        status.alarm_high, status.alarm_low, status.zone};

endmodule

@@ tb/window_alarm_with_hysteresis_delay_tb.sv @@
// Self-checking testbench for the window alarm with hysteresis and confirmation delay.
module window_alarm_with_hysteresis_delay_tb;
   import wahd_pkg::*;

   localparam int SAMPLE_W = SAMPLE_BITS_DEF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [SAMPLE_W-1:0]    req_tdata = '0;
   logic                   req_tuser = KIND_SAMPLE;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Predicted block state and register copy
   cfg_type  cfg_now;
   zone_type zone_now;
   logic     alarm_lo_now;
   logic     alarm_hi_now;
   logic [DELAY_BITS-1:0] lo_cnt;
   logic [DELAY_BITS-1:0] hi_cnt;
   logic     lo_run;
   logic     hi_run;

   status_type expected_status[$];
   int  errors = 0;
   int  hold_cycles = 0;
   bit  src_gaps = 1'b0;
   bit  sink_stalls = 1'b0;
   bit  calm = 1'b0;

   window_alarm_with_hysteresis_delay #(
      .SAMPLE_BITS(SAMPLE_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Stall the result side in random bursts
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
      end else if (!calm && sink_stalls && $urandom_range(0, 7) == 0) begin
         hold_cycles = $urandom_range(1, 12);
      end
      rsp_tready <= (hold_cycles == 0);
   end

   // Compare each result word with the oldest prediction
   always @(posedge clock) begin
      status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_status.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_status.pop_front();
            if (rsp_tdata[1:0] !== want.zone) begin
               $display("%0t: zone expected %0d actual %0d", $time, want.zone, rsp_tdata[1:0]);
               errors++;
            end
            if (rsp_tdata[2] !== want.alarm_low) begin
               $display("%0t: alarm_low expected %0b actual %0b", $time, want.alarm_low,
                        rsp_tdata[2]);
               errors++;
            end
            if (rsp_tdata[3] !== want.alarm_high) begin
               $display("%0t: alarm_high expected %0b actual %0b", $time, want.alarm_high,
                        rsp_tdata[3]);
               errors++;
            end
            if (rsp_tdata[RSP_DATA_BITS-1:4] !== '0) begin
               $display("%0t: padding expected 0 actual %h", $time, rsp_tdata[RSP_DATA_BITS-1:4]);
               errors++;
            end
         end
      end
   end

   // Advance the predicted state by one word and queue the status it leaves
   function automatic void advance_alarm_state(logic kind, logic [SAMPLE_W-1:0] value);
      int s;
      int hi_up;
      int hi_dn;
      int lo_up;
      int lo_dn;
      status_type st;
      s     = int'($signed(value));
      hi_up = int'($signed(cfg_now.high_limit)) + int'({1'b0, cfg_now.hysteresis});
      hi_dn = int'($signed(cfg_now.high_limit)) - int'({1'b0, cfg_now.hysteresis});
      lo_up = int'($signed(cfg_now.low_limit)) + int'({1'b0, cfg_now.hysteresis});
      lo_dn = int'($signed(cfg_now.low_limit)) - int'({1'b0, cfg_now.hysteresis});
      if (kind == KIND_TICK) begin
         // Count the running delays down; confirm only if the zone held
         if (lo_run) begin
            if (lo_cnt <= 1) begin
               lo_cnt = '0;
               lo_run = 1'b0;
               if (zone_now == ZONE_LOW) alarm_lo_now = 1'b1;
            end else begin
               lo_cnt--;
            end
         end
         if (hi_run) begin
            if (hi_cnt <= 1) begin
               hi_cnt = '0;
               hi_run = 1'b0;
               if (zone_now == ZONE_HIGH) alarm_hi_now = 1'b1;
            end else begin
               hi_cnt--;
            end
         end
      end else begin
         // Move the zone; the high test wins where the windows overlap
         if ((zone_now != ZONE_HIGH) && s > hi_up) begin
            zone_now     = ZONE_HIGH;
            alarm_lo_now = 1'b0;
            hi_cnt       = cfg_now.high_delay;
            hi_run       = 1'b1;
         end else if ((zone_now != ZONE_LOW) && s < lo_dn) begin
            zone_now     = ZONE_LOW;
            alarm_hi_now = 1'b0;
            lo_cnt       = cfg_now.low_delay;
            lo_run       = 1'b1;
         end else if (zone_now == ZONE_HIGH && s < hi_dn) begin
            zone_now     = ZONE_NORMAL;
            alarm_hi_now = 1'b0;
         end else if (zone_now == ZONE_LOW && s > lo_up) begin
            zone_now     = ZONE_NORMAL;
            alarm_lo_now = 1'b0;
         end
      end
      st.zone       = zone_now;
      st.alarm_low  = alarm_lo_now;
      st.alarm_high = alarm_hi_now;
      expected_status.push_back(st);
   endfunction

   // Offer one word, with an optional source gap first, and predict on acceptance
   task automatic send_word(logic kind, logic [SAMPLE_W-1:0] value);
      if (src_gaps && !calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
      advance_alarm_state(kind, value);
   endtask

   // Drop the request and let every pending result drain
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write all five registers while the block is idle
   task automatic program_alarm(cfg_type c);
      wait_quiet();
      put_reg(CSR_HIGH_LIMIT, c.high_limit);
      put_reg(CSR_LOW_LIMIT, c.low_limit);
      put_reg(CSR_HYSTERESIS, {1'b0, c.hysteresis});
      put_reg(CSR_LOW_DELAY, c.low_delay);
      put_reg(CSR_HIGH_DELAY, c.high_delay);
      csr_we  <= 1'b0;
      cfg_now = c;
   endtask

   function automatic cfg_type make_cfg(int hi, int lo, int hy, int lo_dly, int hi_dly);
      cfg_type c;
      c.high_limit = 16'(hi);
      c.low_limit  = 16'(lo);
      c.hysteresis = 15'(hy);
      c.low_delay  = 16'(lo_dly);
      c.high_delay = 16'(hi_dly);
      return c;
   endfunction

   // Mostly ordered windows with short delays, sometimes anything at all
   function automatic cfg_type random_cfg();
      int hi;
      int lo;
      int hy;
      hi = int'($urandom_range(0, 40000)) - 20000;
      lo = hi - int'($urandom_range(0, 8000));
      if ($urandom_range(0, 4) == 0) begin
         hi = int'($urandom_range(0, 65535)) - 32768;
         lo = int'($urandom_range(0, 65535)) - 32768;
      end
      hy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 300);
      return make_cfg(hi, lo, hy,
                      ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6),
                      ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6));
   endfunction

   // Pick a sample near one of the four switching points, or anywhere
   function automatic logic [SAMPLE_W-1:0] near_edge_sample();
      int hi;
      int lo;
      int hy;
      int t;
      hi = int'($signed(cfg_now.high_limit));
      lo = int'($signed(cfg_now.low_limit));
      hy = int'({1'b0, cfg_now.hysteresis});
      case ($urandom_range(0, 5))
         0: t = hi + hy;
         1: t = hi - hy;
         2: t = lo + hy;
         3: t = lo - hy;
         default: return SAMPLE_W'($urandom);
      endcase
      t = t + int'($urandom_range(0, 6)) - 3;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return SAMPLE_W'(t);
   endfunction

   task automatic run_phase(int words, int tick_pct);
      for (int n = 0; n < words; n++) begin
         if ($urandom_range(0, 99) < tick_pct) send_word(KIND_TICK, SAMPLE_W'($urandom));
         else send_word(KIND_SAMPLE, near_edge_sample());
      end
   endtask

   // Power-on registers: both limits zero, delays one
   task automatic test_power_on_defaults();
      send_word(KIND_SAMPLE, 16'sd1);
      send_word(KIND_TICK, 16'hFFFF);
      send_word(KIND_SAMPLE, -16'sd1);
      send_word(KIND_TICK, 16'h0000);
   endtask

   // Zone moves, zero delay, expiry after return to normal, counter restart
   task automatic test_window_directed();
      program_alarm(make_cfg(1000, -1000, 50, 3, 0));
      send_word(KIND_SAMPLE, 16'sd1050);
      send_word(KIND_SAMPLE, 16'sd1051);
      send_word(KIND_TICK, 16'h0000);
      send_word(KIND_SAMPLE, 16'sd32767);
      send_word(KIND_SAMPLE, 16'sd949);
      send_word(KIND_SAMPLE, -16'sd32768);
      send_word(KIND_TICK, 16'h0000);
      send_word(KIND_SAMPLE, -16'sd949);
      send_word(KIND_TICK, 16'h0000);
      send_word(KIND_TICK, 16'h0000);
      send_word(KIND_SAMPLE, -16'sd1051);
      send_word(KIND_TICK, 16'h0000);
      send_word(KIND_SAMPLE, 16'sd2000);
      send_word(KIND_SAMPLE, -16'sd2000);
      send_word(KIND_TICK, 16'h0000);
      send_word(KIND_TICK, 16'h0000);
      send_word(KIND_TICK, 16'h0000);
   endtask

   // High limit below low limit, then the widest band at the range ends
   task automatic test_overlap_and_extremes();
      program_alarm(make_cfg(-100, 100, 0, 65535, 65535));
      send_word(KIND_SAMPLE, -16'sd150);
      send_word(KIND_SAMPLE, 16'sd0);
      program_alarm(make_cfg(32767, -32768, 32767, 1, 1));
      send_word(KIND_SAMPLE, 16'sd32767);
      send_word(KIND_SAMPLE, -16'sd32768);
      send_word(KIND_TICK, 16'h0000);
   endtask

   task automatic test_random_sweep();
      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
      program_alarm(make_cfg(32767, -32768, 32767, 65535, 65535));
      run_phase(60, 40);
      program_alarm(make_cfg(500, -500, 20, 0, 0));
      run_phase(60, 40);
      for (int p = 0; p < 11; p++) begin
         src_gaps    = ($urandom_range(0, 3) != 0);
         sink_stalls = ($urandom_range(0, 3) != 0);
         program_alarm(random_cfg());
         run_phase(80, 35);
      end
      // Turn off source gaps and sink stalls for the last stretch
      calm = 1'b1;
      program_alarm(make_cfg(-32768, 32767, 0, 2, 3));
      run_phase(40, 30);
      program_alarm(random_cfg());
      run_phase(160, 35);
   endtask

   initial begin
      cfg_now      = make_cfg(0, 0, 0, 1, 1);
      zone_now     = ZONE_NORMAL;
      alarm_lo_now = 1'b0;
      alarm_hi_now = 1'b0;
      lo_cnt       = '0;
      hi_cnt       = '0;
      lo_run       = 1'b0;
      hi_run       = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_power_on_defaults();
      test_window_directed();
      test_overlap_and_extremes();
      test_random_sweep();

      // Drain, bounded, then allow the pipeline to settle
      req_tvalid <= 1'b0;
      for (int w = 0; w < 5000 && expected_status.size() != 0; w++) @(posedge clock);
      if (expected_status.size() != 0) begin
         $display("%0t: %0d result words expected, actual none", $time, expected_status.size());
         errors++;
      end
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("window_alarm_with_hysteresis_delay_tb passed");
      end else begin
         $display("window_alarm_with_hysteresis_delay_tb failed");
      end
      $finish;
   end

   // Hard stop if the handshakes hang
   initial begin
      #3000000;
      $display("window_alarm_with_hysteresis_delay_tb failed");
      $finish;
   end

endmodule
